// File: src/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // Item function codes
    typedef enum logic [2:0] {
        FN_TICK  = 3'd0,
        FN_RESET = 3'd1,
        FN_WRITE = 3'd2,
        FN_READ  = 3'd3,
        FN_WAIT1 = 3'd4
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW    = 3'd0,
        CFG_SLOT_LOW     = 3'd1,
        CFG_WRITE_HOLD   = 3'd2,
        CFG_RECOVERY     = 3'd3,
        CFG_READ_WAIT    = 3'd4,
        CFG_PRES_MIN     = 3'd5,
        CFG_PRES_MAX     = 3'd6,
        CFG_PRES_TIMEOUT = 3'd7
    } cfg_idx_t;

    localparam logic [9:0]  RESET_LOW_RST    = 10'd480;
    localparam logic [3:0]  SLOT_LOW_RST     = 4'd1;
    localparam logic [6:0]  WRITE_HOLD_RST   = 7'd70;
    localparam logic [5:0]  RECOVERY_RST     = 6'd5;
    localparam logic [6:0]  READ_WAIT_RST    = 7'd35;
    localparam logic [9:0]  PRES_MIN_RST     = 10'd60;
    localparam logic [9:0]  PRES_MAX_RST     = 10'd240;
    localparam logic [15:0] PRES_TIMEOUT_RST = 16'hffff;

    localparam logic [15:0] PULSE_MAX = 16'hffff;
    localparam logic [2:0]  LAST_BIT  = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_MEAS = 4'd3,
        PH_W_LOW    = 4'd4,
        PH_W_HOLD   = 4'd5,
        PH_W_REC    = 4'd6,
        PH_R_LOW    = 4'd7,
        PH_R_SAMP   = 4'd8,
        PH_R_WAIT   = 4'd9
    } phase_t;

    typedef struct packed {
        logic [9:0]  reset_low;
        logic [3:0]  slot_low;
        logic [6:0]  write_hold;
        logic [5:0]  recovery;
        logic [6:0]  read_wait;
        logic [9:0]  pres_min;
        logic [9:0]  pres_max;
        logic [15:0] pres_timeout;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       presence_ok;
    } res_t;

    typedef struct packed {
        logic presence_flag;
        logic pulse_seen;
    } stat_t;

endpackage

// File: src/owbm_cfg_regs.sv
// Configuration register file for the one-wire bus master.
`timescale 1ns / 1ps

module owbm_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output owbm_pkg::cfg_t                     cfg
);

    owbm_pkg::cfg_t cfg_reg;
    owbm_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (owbm_pkg::cfg_idx_t'(cfg_index))
                owbm_pkg::CFG_RESET_LOW:    cfg_next.reset_low    = cfg_data[9:0];
                owbm_pkg::CFG_SLOT_LOW:     cfg_next.slot_low     = cfg_data[3:0];
                owbm_pkg::CFG_WRITE_HOLD:   cfg_next.write_hold   = cfg_data[6:0];
                owbm_pkg::CFG_RECOVERY:     cfg_next.recovery     = cfg_data[5:0];
                owbm_pkg::CFG_READ_WAIT:    cfg_next.read_wait    = cfg_data[6:0];
                owbm_pkg::CFG_PRES_MIN:     cfg_next.pres_min     = cfg_data[9:0];
                owbm_pkg::CFG_PRES_MAX:     cfg_next.pres_max     = cfg_data[9:0];
                owbm_pkg::CFG_PRES_TIMEOUT: cfg_next.pres_timeout = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low    <= owbm_pkg::RESET_LOW_RST;
            cfg_reg.slot_low     <= owbm_pkg::SLOT_LOW_RST;
            cfg_reg.write_hold   <= owbm_pkg::WRITE_HOLD_RST;
            cfg_reg.recovery     <= owbm_pkg::RECOVERY_RST;
            cfg_reg.read_wait    <= owbm_pkg::READ_WAIT_RST;
            cfg_reg.pres_min     <= owbm_pkg::PRES_MIN_RST;
            cfg_reg.pres_max     <= owbm_pkg::PRES_MAX_RST;
            cfg_reg.pres_timeout <= owbm_pkg::PRES_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/owbm_core.sv
// Bus sequencer: phase machine, slot timer, shift and presence logic.
`timescale 1ns / 1ps

module owbm_core
#(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [2:0]     func,
    input  logic [7:0]     data_byte,
    input  logic           line_level,
    input  owbm_pkg::cfg_t cfg,
    output owbm_pkg::res_t res,
    output owbm_pkg::stat_t stat
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TM_MAX = {TIMER_BITS{1'b1}};

    owbm_pkg::phase_t      phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [15:0]           len_reg, len_next;
    logic                  seen_reg, seen_next;
    logic                  pres_reg, pres_next;
    logic [7:0]            wdata_reg, wdata_next;
    logic                  wmode_reg, wmode_next;
    logic                  done;

    // Interval loads; a zero register counts as one tick
    logic [TIMER_BITS-1:0] ld_rst, ld_slot, ld_hold, ld_rec, ld_rwait;
    logic [TIMER_BITS-1:0] tm_dec, tm_up;
    logic                  tm_last, tm_out, in_window;
    logic [15:0]           lim;

    always_comb
    begin
        ld_rst   = (cfg.reset_low  == '0) ? TIMER_BITS'(1) : TIMER_BITS'(cfg.reset_low);
        ld_slot  = (cfg.slot_low   == '0) ? TIMER_BITS'(1) : TIMER_BITS'(cfg.slot_low);
        ld_hold  = (cfg.write_hold == '0) ? TIMER_BITS'(1) : TIMER_BITS'(cfg.write_hold);
        ld_rec   = (cfg.recovery   == '0) ? TIMER_BITS'(1) : TIMER_BITS'(cfg.recovery);
        ld_rwait = (cfg.read_wait  == '0) ? TIMER_BITS'(1) : TIMER_BITS'(cfg.read_wait);
        lim      = (cfg.pres_timeout == '0) ? 16'd1 : cfg.pres_timeout;
        tm_last  = (timer_reg <= TIMER_BITS'(1));
        tm_dec   = timer_reg - TIMER_BITS'(1);
        tm_up    = (timer_reg == TM_MAX) ? timer_reg : timer_reg + TIMER_BITS'(1);
        tm_out   = (CMP_W'(tm_up) >= CMP_W'(lim)) || (tm_up == TM_MAX);
        in_window = (len_reg >= 16'(cfg.pres_min)) && (len_reg <= 16'(cfg.pres_max));
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        pres_next  = pres_reg;
        wdata_next = wdata_reg;
        wmode_next = wmode_reg;
        done       = 1'b0;
        if (step)
        begin
            if (phase_reg == owbm_pkg::PH_IDLE)
            begin
                case (owbm_pkg::func_t'(func))
                    owbm_pkg::FN_RESET:
                    begin
                        phase_next = owbm_pkg::PH_RST_LOW;
                        timer_next = ld_rst;
                        seen_next  = 1'b0;
                        len_next   = '0;
                        pres_next  = 1'b0;
                    end
                    owbm_pkg::FN_WRITE:
                    begin
                        phase_next = owbm_pkg::PH_W_LOW;
                        timer_next = ld_slot;
                        wdata_next = data_byte;
                        bit_next   = '0;
                    end
                    owbm_pkg::FN_READ:
                    begin
                        phase_next = owbm_pkg::PH_R_LOW;
                        timer_next = ld_slot;
                        bit_next   = '0;
                        wmode_next = 1'b0;
                        shift_next = '0;
                    end
                    owbm_pkg::FN_WAIT1:
                    begin
                        phase_next = owbm_pkg::PH_R_LOW;
                        timer_next = ld_slot;
                        bit_next   = '0;
                        wmode_next = 1'b1;
                    end
                    default:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                    end
                endcase
            end
            else
            begin
                case (phase_reg)
                    owbm_pkg::PH_RST_LOW:
                    begin
                        if (tm_last)
                        begin
                            phase_next = owbm_pkg::PH_RST_WAIT;
                            timer_next = '0;
                        end
                        else
                        begin
                            timer_next = tm_dec;
                        end
                    end
                    owbm_pkg::PH_RST_WAIT:
                    begin
                        timer_next = tm_up;
                        if (!line_level)
                        begin
                            phase_next = owbm_pkg::PH_RST_MEAS;
                            len_next   = 16'd1;
                        end
                        done = tm_out;
                    end
                    owbm_pkg::PH_RST_MEAS:
                    begin
                        timer_next = tm_up;
                        if (line_level)
                        begin
                            seen_next = 1'b1;
                            pres_next = in_window;
                            done      = 1'b1;
                        end
                        else
                        begin
                            if (len_reg != owbm_pkg::PULSE_MAX)
                            begin
                                len_next = len_reg + 16'd1;
                            end
                            done = tm_out;
                        end
                    end
                    owbm_pkg::PH_W_LOW:
                    begin
                        if (tm_last)
                        begin
                            phase_next = owbm_pkg::PH_W_HOLD;
                            timer_next = ld_hold;
                        end
                        else
                        begin
                            timer_next = tm_dec;
                        end
                    end
                    owbm_pkg::PH_W_HOLD:
                    begin
                        if (tm_last)
                        begin
                            phase_next = owbm_pkg::PH_W_REC;
                            timer_next = ld_rec;
                        end
                        else
                        begin
                            timer_next = tm_dec;
                        end
                    end
                    owbm_pkg::PH_W_REC:
                    begin
                        if (tm_last)
                        begin
                            timer_next = '0;
                            if (bit_reg == owbm_pkg::LAST_BIT)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 3'd1;
                                wdata_next = {1'b0, wdata_reg[7:1]};
                                phase_next = owbm_pkg::PH_W_LOW;
                                timer_next = ld_slot;
                            end
                        end
                        else
                        begin
                            timer_next = tm_dec;
                        end
                    end
                    owbm_pkg::PH_R_LOW:
                    begin
                        if (tm_last)
                        begin
                            timer_next = '0;
                            phase_next = owbm_pkg::PH_R_SAMP;
                        end
                        else
                        begin
                            timer_next = tm_dec;
                        end
                    end
                    owbm_pkg::PH_R_SAMP:
                    begin
                        if (wmode_reg)
                        begin
                            // a slot reading one ends the wait
                            if (line_level)
                            begin
                                bit_next = owbm_pkg::LAST_BIT;
                            end
                        end
                        else
                        begin
                            shift_next = {line_level, shift_reg[7:1]};
                        end
                        phase_next = owbm_pkg::PH_R_WAIT;
                        timer_next = ld_rwait;
                    end
                    owbm_pkg::PH_R_WAIT:
                    begin
                        if (tm_last)
                        begin
                            timer_next = '0;
                            if (bit_reg == owbm_pkg::LAST_BIT)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                if (!wmode_reg)
                                begin
                                    bit_next = bit_reg + 3'd1;
                                end
                                phase_next = owbm_pkg::PH_R_LOW;
                                timer_next = ld_slot;
                            end
                        end
                        else
                        begin
                            timer_next = tm_dec;
                        end
                    end
                    default:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                    end
                endcase
                if (done)
                begin
                    phase_next = owbm_pkg::PH_IDLE;
                end
            end
        end
    end

    // Outputs: results from the state after this beat, status from the registers
    always_comb
    begin
        res.drive_low   = 1'b0;
        res.busy        = (phase_next != owbm_pkg::PH_IDLE);
        res.done        = done;
        res.read_byte   = shift_next;
        res.presence_ok = pres_next;
        case (phase_next)
            owbm_pkg::PH_RST_LOW,
            owbm_pkg::PH_W_LOW,
            owbm_pkg::PH_R_LOW:  res.drive_low = 1'b1;
            owbm_pkg::PH_W_HOLD: res.drive_low = ~wdata_next[0];
            default:             res.drive_low = 1'b0;
        endcase
        stat.presence_flag = pres_reg;
        stat.pulse_seen    = seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= owbm_pkg::PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            len_reg   <= '0;
            seen_reg  <= 1'b0;
            pres_reg  <= 1'b0;
            wdata_reg <= '0;
            wmode_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            pres_reg  <= pres_next;
            wdata_reg <= wdata_next;
            wmode_reg <= wmode_next;
        end
    end

endmodule

// File: src/one_wire_bus_master_top.sv
// Top level of the one-wire bus master: input register, sequencer, result register.
`timescale 1ns / 1ps

// Channel   Handshake            Beat contents
// -------   ------------------   -------------------------------------------------
// in        in_valid / in_stall  func, data_byte, line_level
// out       out_valid/out_stall  drive_low, busy_res, done_res, read_byte,
//                                presence_ok
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat per clock cycle while the result is not stalled; a beat passes from the
// input register through the sequencer's combinational update into the result
// register. Bus timing is counted in input beats of any function, not clocks.
// Reset puts the sequencer in idle, all flags at zero, and the timing
// registers at their defaults. A stalled result holds both registers; in_stall
// rises only when the input register is full and the result cannot drain.

module one_wire_bus_master_top
#(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      func,
    input  logic [7:0]                      data_byte,
    input  logic                            line_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            drive_low,
    output logic                            busy_res,
    output logic                            done_res,
    output logic [7:0]                      read_byte,
    output logic                            presence_ok,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data
);

    owbm_pkg::cfg_t  cfg;
    owbm_pkg::res_t  res;
    owbm_pkg::stat_t stat;

    logic       in_vld_reg, in_vld_next;
    logic [2:0] func_reg;
    logic [7:0] data_reg;
    logic       level_reg;
    logic       out_vld_reg, out_vld_next;
    owbm_pkg::res_t res_reg;

    logic out_free;
    logic step;
    logic in_take;

    // Result register drains when empty or taken this cycle
    assign out_free = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (step)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    owbm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_core #(.TIMER_BITS(TIMER_BITS)) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .func       (func_reg),
        .data_byte  (data_reg),
        .line_level (level_reg),
        .cfg        (cfg),
        .res        (res),
        .stat       (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg  <= func;
            data_reg  <= data_byte;
            level_reg <= line_level;
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_vld_reg;
    assign drive_low   = res_reg.drive_low;
    assign busy_res    = res_reg.busy;
    assign done_res    = res_reg.done;
    assign read_byte   = res_reg.read_byte;
    assign presence_ok = res_reg.presence_ok;

    // A good presence verdict is only ever given after a pulse was seen
    a_pres_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        stat.presence_flag |-> stat.pulse_seen)
        else $error("presence flag set without a measured pulse");

    // A finished command never reports busy on the same beat
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(done_res && busy_res))
        else $error("done and busy on one result beat");

    // An idle result never pulls the line low
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> !drive_low)
        else $error("line driven while idle");

    // A held input beat moves to the result register when it can drain
    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !(out_valid && out_stall)) |=> out_valid)
        else $error("input beat lost between stages");

endmodule
